/* rtl/core/usbep0_pkg.sv */
// Shared types and constants for the endpoint 0 standard request handler.
// Used by usbep0_ctrl, usbep0_dp and the top level; depends on nothing else.
`default_nettype none

package usbep0_pkg;

  // Input command codes.
  localparam logic [2:0] CMD_BUS_RESET = 3'd0;
  localparam logic [2:0] CMD_SETUP     = 3'd1;
  localparam logic [2:0] CMD_IN_DONE   = 3'd2;
  localparam logic [2:0] CMD_OUT_DONE  = 3'd3;
  localparam logic [2:0] CMD_LOAD_DESC = 3'd4;

  // Standard request codes (bRequest).
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESC          = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

  // bmRequestType bits that mark a class or vendor request.
  localparam logic [7:0] TYPE_MASK = 8'h60;

  // Control endpoint addresses.
  localparam logic [7:0] EP_OUT0 = 8'h00;
  localparam logic [7:0] EP_IN0  = 8'h80;

  // Action codes on the result port.
  typedef enum logic [3:0] {
    ACT_ACK         = 4'd0,
    ACT_IN          = 4'd1,
    ACT_CLR_OUT     = 4'd2,
    ACT_STALL       = 4'd3,
    ACT_SET_ADDR    = 4'd4,
    ACT_CLASS_SETUP = 4'd5,
    ACT_CLASS_IN    = 4'd6,
    ACT_CLASS_CFG   = 4'd7,
    ACT_CLASS_OUT   = 4'd8
  } act_e;

  // Kinds of result the controller asks the datapath to form.
  typedef enum logic [3:0] {
    RES_ACK,
    RES_IN_PKT,
    RES_IN_ZLP,
    RES_IN_STATUS,
    RES_IN_CFG,
    RES_CLR_OUT,
    RES_STALL_OUT,
    RES_STALL_IN,
    RES_SET_ADDR,
    RES_CLASS_SETUP,
    RES_CLASS_IN,
    RES_CLASS_CFG,
    RES_CLASS_OUT
  } res_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch_in;
    logic save_setup;
    logic bus_reset;
    logic load_desc;
    logic set_config;
    logic scan_clr;
    logic scan_inc;
    logic xfer_load;
    logic pkt_adv;
    logic set_done;
    logic emit;
    res_e res;
    logic last;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [2:0] cmd;
    logic       is_class;
    logic [7:0] req;
    logic       saved_std;
    logic [7:0] saved_req;
    logic       ep_is_in0;
    logic       scan_end;
    logic       scan_hit;
    logic       pkt_more;
    logic       pkt_exact;
    logic       xfer_done;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/usb_ep0_standard_request_handler.sv */
// Top level of the USB endpoint 0 standard request handler.
// Joins usbep0_ctrl and usbep0_dp; depends on usbep0_pkg.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------------------
//   item in   start, busy          cmd_i .. desc_base_i, taken when start && !busy
//   result    strobe_o (1 cycle)   action_o .. last_o, up to three per item
//
// An item is decoded in ST_EXEC in the cycle after it is taken; its first result
// shows in the cycle after decode and the next results follow on consecutive
// cycles. A descriptor request first scans the descriptor table one entry per
// cycle.
// Reset clears the request, transfer and configuration state and the table's
// valid bits; no clearing pass is needed. Results cannot be held off.
`default_nettype none

module usb_ep0_standard_request_handler #(
  parameter int EP0_SIZE     = 64,
  parameter int DESC_ENTRIES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_code_i,
  input  wire logic [15:0] setup_value_i,
  input  wire logic [15:0] setup_index_i,
  input  wire logic [15:0] setup_length_i,
  input  wire logic [7:0]  endpoint_i,
  input  wire logic [6:0]  out_count_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [15:0] desc_base_i,
  output logic             strobe_o,
  output logic [3:0]       action_o,
  output logic [7:0]       ep_addr_o,
  output logic [6:0]       byte_count_o,
  output logic             from_memory_o,
  output logic [15:0]      mem_addr_o,
  output logic [7:0]       inline_byte_o,
  output logic [6:0]       device_address_o,
  output logic [15:0]      config_value_o,
  output logic             last_o
);

  usbep0_pkg::dp_cmd_t dp_cmd;
  usbep0_pkg::dp_sts_t dp_sts;

  usbep0_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd)
  );

  usbep0_dp #(
    .EP0_SIZE     (EP0_SIZE),
    .DESC_ENTRIES (DESC_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .cmd_in_i         (cmd_i),
    .request_type_i   (request_type_i),
    .request_code_i   (request_code_i),
    .setup_value_i    (setup_value_i),
    .setup_index_i    (setup_index_i),
    .setup_length_i   (setup_length_i),
    .endpoint_i       (endpoint_i),
    .out_count_i      (out_count_i),
    .slot_i           (slot_i),
    .desc_base_i      (desc_base_i),
    .strobe_o         (strobe_o),
    .action_o         (action_o),
    .ep_addr_o        (ep_addr_o),
    .byte_count_o     (byte_count_o),
    .from_memory_o    (from_memory_o),
    .mem_addr_o       (mem_addr_o),
    .inline_byte_o    (inline_byte_o),
    .device_address_o (device_address_o),
    .config_value_o   (config_value_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

/* rtl/core/usbep0_dp.sv */
// Datapath of the endpoint 0 handler: captured item, saved setup, transfer
// state, descriptor table with its scan counter, and the result register.
// Depends on usbep0_pkg.
`default_nettype none

module usbep0_dp #(
  parameter int EP0_SIZE     = 64,
  parameter int DESC_ENTRIES = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire usbep0_pkg::dp_cmd_t   cmd_i,
  output usbep0_pkg::dp_sts_t        sts_o,
  input  wire logic [2:0]            cmd_in_i,
  input  wire logic [7:0]            request_type_i,
  input  wire logic [7:0]            request_code_i,
  input  wire logic [15:0]           setup_value_i,
  input  wire logic [15:0]           setup_index_i,
  input  wire logic [15:0]           setup_length_i,
  input  wire logic [7:0]            endpoint_i,
  input  wire logic [6:0]            out_count_i,
  input  wire logic [2:0]            slot_i,
  input  wire logic [15:0]           desc_base_i,
  output logic                       strobe_o,
  output logic [3:0]                 action_o,
  output logic [7:0]                 ep_addr_o,
  output logic [6:0]                 byte_count_o,
  output logic                       from_memory_o,
  output logic [15:0]                mem_addr_o,
  output logic [7:0]                 inline_byte_o,
  output logic [6:0]                 device_address_o,
  output logic [15:0]                config_value_o,
  output logic                       last_o
);

  localparam int IDX_W  = (DESC_ENTRIES > 1) ? $clog2(DESC_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(DESC_ENTRIES + 1);
  localparam int SLOT_W = (IDX_W > 3) ? IDX_W : 3;
  localparam logic [16:0] PKT_STEP = 17'(EP0_SIZE);
  localparam logic [6:0]  PKT_MAX  = 7'(EP0_SIZE);

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] len;
    logic [15:0] key_index;
    logic [15:0] key_value;
  } desc_t;

  // Captured input item.
  logic [2:0]  cmd_q;
  logic [7:0]  type_q, code_q, ep_q;
  logic [15:0] value_q, index_q, length_q, base_in_q;
  logic [6:0]  count_q;
  logic [2:0]  slot_q;

  // Request and transfer state.
  logic [7:0]  saved_type_q, saved_request_q;
  logic [15:0] saved_value_q;
  logic [15:0] xfer_base_q, xfer_length_q;
  logic [16:0] xfer_offset_q;
  logic        xfer_done_q;
  logic [15:0] cur_cfg_q;

  // Descriptor table.
  desc_t                   desc_mem [DESC_ENTRIES];
  logic [DESC_ENTRIES-1:0] desc_valid_q;
  logic [CNT_W-1:0]        scan_q;

  logic [SLOT_W-1:0] slot_ext;
  logic              slot_ok;
  logic [IDX_W-1:0]  scan_idx;
  desc_t             scan_entry;
  logic              scan_end;
  logic [16:0]       remain;
  logic [15:0]       reply_len;

  // Result register.
  logic        strobe_q, last_q, from_mem_q;
  logic [3:0]  action_q;
  logic [7:0]  ep_addr_q, inline_q;
  logic [6:0]  count_out_q, dev_addr_q;
  logic [15:0] mem_addr_q, cfg_out_q;

  usbep0_pkg::act_e res_act;
  logic [7:0]       res_ep, res_inline;
  logic [6:0]       res_count, res_dev;
  logic             res_from_mem;
  logic [15:0]      res_addr, res_cfg;

  assign slot_ext   = SLOT_W'(slot_q);
  assign slot_ok    = 32'(slot_q) < 32'(DESC_ENTRIES);
  assign scan_idx   = scan_q[IDX_W-1:0];
  assign scan_entry = desc_mem[scan_idx];
  assign scan_end   = (scan_q == CNT_W'(DESC_ENTRIES));
  assign remain     = 17'(xfer_length_q) - xfer_offset_q;
  assign reply_len  = (length_q < scan_entry.len) ? length_q : scan_entry.len;

  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.is_class  = (type_q & usbep0_pkg::TYPE_MASK) != 8'd0;
    sts_o.req       = code_q;
    sts_o.saved_std = (saved_type_q & usbep0_pkg::TYPE_MASK) == 8'd0;
    sts_o.saved_req = saved_request_q;
    sts_o.ep_is_in0 = (ep_q == usbep0_pkg::EP_IN0);
    sts_o.scan_end  = scan_end;
    sts_o.scan_hit  = !scan_end && desc_valid_q[scan_idx] &&
                      (scan_entry.key_value == value_q) &&
                      (scan_entry.key_index == index_q);
    sts_o.pkt_more  = xfer_offset_q < 17'(xfer_length_q);
    sts_o.pkt_exact = xfer_offset_q == 17'(xfer_length_q);
    sts_o.xfer_done = xfer_done_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q     <= cmd_in_i;
      type_q    <= request_type_i;
      code_q    <= request_code_i;
      value_q   <= setup_value_i;
      index_q   <= setup_index_i;
      length_q  <= setup_length_i;
      ep_q      <= endpoint_i;
      count_q   <= out_count_i;
      slot_q    <= slot_i;
      base_in_q <= desc_base_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_desc && slot_ok) begin
      desc_mem[slot_ext[IDX_W-1:0]] <= '{base: base_in_q, len: length_q,
                                         key_index: index_q, key_value: value_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_type_q    <= '0;
      saved_request_q <= '0;
      saved_value_q   <= '0;
      xfer_base_q     <= '0;
      xfer_offset_q   <= '0;
      xfer_length_q   <= '0;
      xfer_done_q     <= 1'b0;
      cur_cfg_q       <= '0;
      desc_valid_q    <= '0;
      scan_q          <= '0;
    end else begin
      if (cmd_i.bus_reset) begin
        saved_type_q    <= '0;
        saved_request_q <= '0;
        saved_value_q   <= '0;
        xfer_base_q     <= '0;
        xfer_offset_q   <= '0;
        xfer_length_q   <= '0;
        xfer_done_q     <= 1'b0;
      end
      if (cmd_i.save_setup) begin
        saved_type_q    <= type_q;
        saved_request_q <= code_q;
        saved_value_q   <= value_q;
      end
      if (cmd_i.set_config) begin
        cur_cfg_q <= value_q;
      end
      if (cmd_i.load_desc && slot_ok) begin
        desc_valid_q[slot_ext[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      if (cmd_i.xfer_load) begin
        xfer_base_q   <= scan_entry.base;
        xfer_offset_q <= '0;
        xfer_length_q <= reply_len;
        xfer_done_q   <= 1'b0;
      end
      if (cmd_i.pkt_adv) begin
        xfer_offset_q <= xfer_offset_q + PKT_STEP;
      end
      if (cmd_i.set_done) begin
        xfer_done_q <= 1'b1;
      end
    end
  end

  // Form the fields of the requested result; unused fields stay zero.
  always_comb begin
    res_act      = usbep0_pkg::ACT_ACK;
    res_ep       = usbep0_pkg::EP_OUT0;
    res_count    = '0;
    res_from_mem = 1'b0;
    res_addr     = '0;
    res_inline   = '0;
    res_dev      = '0;
    res_cfg      = '0;
    case (cmd_i.res)
      usbep0_pkg::RES_ACK: begin
        res_act = usbep0_pkg::ACT_ACK;
      end
      usbep0_pkg::RES_IN_PKT: begin
        res_act      = usbep0_pkg::ACT_IN;
        res_ep       = usbep0_pkg::EP_IN0;
        res_count    = (remain < 17'(PKT_MAX)) ? remain[6:0] : PKT_MAX;
        res_from_mem = 1'b1;
        res_addr     = xfer_base_q + xfer_offset_q[15:0];
      end
      usbep0_pkg::RES_IN_ZLP: begin
        res_act = usbep0_pkg::ACT_IN;
        res_ep  = usbep0_pkg::EP_IN0;
      end
      usbep0_pkg::RES_IN_STATUS: begin
        res_act   = usbep0_pkg::ACT_IN;
        res_ep    = usbep0_pkg::EP_IN0;
        res_count = 7'd2;
      end
      usbep0_pkg::RES_IN_CFG: begin
        res_act    = usbep0_pkg::ACT_IN;
        res_ep     = usbep0_pkg::EP_IN0;
        res_count  = 7'd1;
        res_inline = cur_cfg_q[7:0];
      end
      usbep0_pkg::RES_CLR_OUT: begin
        res_act = usbep0_pkg::ACT_CLR_OUT;
      end
      usbep0_pkg::RES_STALL_OUT: begin
        res_act = usbep0_pkg::ACT_STALL;
      end
      usbep0_pkg::RES_STALL_IN: begin
        res_act = usbep0_pkg::ACT_STALL;
        res_ep  = usbep0_pkg::EP_IN0;
      end
      usbep0_pkg::RES_SET_ADDR: begin
        res_act = usbep0_pkg::ACT_SET_ADDR;
        res_dev = saved_value_q[6:0];
      end
      usbep0_pkg::RES_CLASS_SETUP: begin
        res_act = usbep0_pkg::ACT_CLASS_SETUP;
      end
      usbep0_pkg::RES_CLASS_IN: begin
        res_act = usbep0_pkg::ACT_CLASS_IN;
        res_ep  = ep_q;
      end
      usbep0_pkg::RES_CLASS_CFG: begin
        res_act = usbep0_pkg::ACT_CLASS_CFG;
        res_cfg = value_q;
      end
      usbep0_pkg::RES_CLASS_OUT: begin
        res_act   = usbep0_pkg::ACT_CLASS_OUT;
        res_ep    = ep_q;
        res_count = count_q;
      end
      default: begin
        res_act = usbep0_pkg::ACT_ACK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      action_q    <= res_act;
      ep_addr_q   <= res_ep;
      count_out_q <= res_count;
      from_mem_q  <= res_from_mem;
      mem_addr_q  <= res_addr;
      inline_q    <= res_inline;
      dev_addr_q  <= res_dev;
      cfg_out_q   <= res_cfg;
      last_q      <= cmd_i.last;
    end
  end

  assign strobe_o         = strobe_q;
  assign action_o         = action_q;
  assign ep_addr_o        = ep_addr_q;
  assign byte_count_o     = count_out_q;
  assign from_memory_o    = from_mem_q;
  assign mem_addr_o       = mem_addr_q;
  assign inline_byte_o    = inline_q;
  assign device_address_o = dev_addr_q;
  assign config_value_o   = cfg_out_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

/* rtl/core/usbep0_ctrl.sv */
// Controller of the endpoint 0 handler: sequences command decode, the
// descriptor scan and the results of each item. Depends on usbep0_pkg.
`default_nettype none

module usbep0_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire usbep0_pkg::dp_sts_t  sts_i,
  output usbep0_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_NEXT,
    ST_ZLP_CLR,
    ST_CLR_LAST,
    ST_STALL_IN_LAST
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res = usbep0_pkg::RES_ACK;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (sts_i.cmd)
          usbep0_pkg::CMD_BUS_RESET: begin
            cmd_o.bus_reset = 1'b1;
            cmd_o.emit      = 1'b1;
            cmd_o.res       = usbep0_pkg::RES_ACK;
            cmd_o.last      = 1'b1;
          end
          usbep0_pkg::CMD_SETUP: begin
            cmd_o.save_setup = 1'b1;
            if (sts_i.is_class) begin
              cmd_o.emit = 1'b1;
              cmd_o.res  = usbep0_pkg::RES_CLASS_SETUP;
              cmd_o.last = 1'b1;
            end else begin
              case (sts_i.req)
                usbep0_pkg::REQ_GET_STATUS: begin
                  cmd_o.emit = 1'b1;
                  cmd_o.res  = usbep0_pkg::RES_IN_STATUS;
                  state_d    = ST_CLR_LAST;
                end
                usbep0_pkg::REQ_SET_ADDRESS: begin
                  cmd_o.emit = 1'b1;
                  cmd_o.res  = usbep0_pkg::RES_IN_ZLP;
                  state_d    = ST_CLR_LAST;
                end
                usbep0_pkg::REQ_GET_DESC: begin
                  cmd_o.scan_clr = 1'b1;
                  state_d        = ST_SEARCH;
                end
                usbep0_pkg::REQ_GET_CONFIGURATION: begin
                  cmd_o.emit = 1'b1;
                  cmd_o.res  = usbep0_pkg::RES_IN_CFG;
                  state_d    = ST_CLR_LAST;
                end
                usbep0_pkg::REQ_SET_CONFIGURATION: begin
                  cmd_o.set_config = 1'b1;
                  cmd_o.emit       = 1'b1;
                  cmd_o.res        = usbep0_pkg::RES_CLASS_CFG;
                  state_d          = ST_ZLP_CLR;
                end
                default: begin
                  cmd_o.emit = 1'b1;
                  cmd_o.res  = usbep0_pkg::RES_STALL_OUT;
                  state_d    = ST_STALL_IN_LAST;
                end
              endcase
            end
          end
          usbep0_pkg::CMD_IN_DONE: begin
            if (sts_i.ep_is_in0 && sts_i.saved_std) begin
              if (sts_i.saved_req == usbep0_pkg::REQ_SET_ADDRESS) begin
                cmd_o.emit = 1'b1;
                cmd_o.res  = usbep0_pkg::RES_SET_ADDR;
                cmd_o.last = 1'b1;
              end else if (sts_i.saved_req == usbep0_pkg::REQ_GET_DESC) begin
                state_d = ST_NEXT;
              end
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.res  = usbep0_pkg::RES_CLASS_IN;
              cmd_o.last = 1'b1;
            end
          end
          usbep0_pkg::CMD_OUT_DONE: begin
            cmd_o.emit = 1'b1;
            cmd_o.res  = usbep0_pkg::RES_CLASS_OUT;
            cmd_o.last = 1'b1;
          end
          usbep0_pkg::CMD_LOAD_DESC: begin
            cmd_o.load_desc = 1'b1;
            cmd_o.emit      = 1'b1;
            cmd_o.res       = usbep0_pkg::RES_ACK;
            cmd_o.last      = 1'b1;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SEARCH: begin
        // One table entry is compared per cycle; the lowest match wins.
        if (sts_i.scan_end) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = usbep0_pkg::RES_STALL_IN;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end else if (sts_i.scan_hit) begin
          cmd_o.xfer_load = 1'b1;
          state_d         = ST_NEXT;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_NEXT: begin
        state_d = ST_IDLE;
        if (sts_i.pkt_more) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res     = usbep0_pkg::RES_IN_PKT;
          cmd_o.last    = 1'b1;
          cmd_o.pkt_adv = 1'b1;
        end else if (!sts_i.xfer_done) begin
          cmd_o.set_done = 1'b1;
          cmd_o.emit     = 1'b1;
          if (sts_i.pkt_exact) begin
            cmd_o.res = usbep0_pkg::RES_IN_ZLP;
            state_d   = ST_CLR_LAST;
          end else begin
            cmd_o.res  = usbep0_pkg::RES_CLR_OUT;
            cmd_o.last = 1'b1;
          end
        end
      end
      ST_ZLP_CLR: begin
        cmd_o.emit = 1'b1;
        cmd_o.res  = usbep0_pkg::RES_IN_ZLP;
        state_d    = ST_CLR_LAST;
      end
      ST_CLR_LAST: begin
        cmd_o.emit = 1'b1;
        cmd_o.res  = usbep0_pkg::RES_CLR_OUT;
        cmd_o.last = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_STALL_IN_LAST: begin
        cmd_o.emit = 1'b1;
        cmd_o.res  = usbep0_pkg::RES_STALL_IN;
        cmd_o.last = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire
